FILE: hw/rtl/mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    OP_TICK = 4'd0, OP_ADD = 4'd1, OP_REMOVE = 4'd2, OP_START_ALL = 4'd3,
    OP_START_ONE = 4'd4, OP_START_FIRE = 4'd5, OP_STOP_ALL = 4'd6,
    OP_STOP_ONE = 4'd7, OP_CALL = 4'd8, OP_FORCE = 4'd9, OP_QUERY = 4'd10
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_CHANGED = 2'd3;

  localparam logic [1:0] MODE_ONCE = 2'd0;
  localparam logic [1:0] MODE_COUNTED = 2'd1;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] ival;
    logic [1:0]  mode;
    logic [15:0] lim;
    logic        en;
    logic [31:0] lt;
    logic [15:0] cnt;
  } slot_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one slot of the ring; rotates with its neighbours while shift is high
module mst_cell import mst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  shift,
  input  wire logic  load,
  input  wire slot_t d_shift,
  input  wire slot_t d_load,
  output slot_t      q
);
  always_ff @(posedge clk) begin
    if (load) q <= d_load;
    else if (shift) q <= d_shift;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/multi_slot_interval_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// results are registered: tick items during the scan, the final item from the done state
// a new item is taken only when idle; the slot ring rotates once per item
// busy is high from acceptance until the ring is back in place
// reset clears the slot count and control; slot contents stay undefined until written
// results are shown for one cycle each, the receiver cannot stall
module multi_slot_interval_timer import mst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  opcode,
  input  wire logic [7:0]  event_id,
  input  wire logic [31:0] now,
  input  wire logic [31:0] new_interval,
  input  wire logic [1:0]  new_mode,
  input  wire logic [15:0] new_limit,
  input  wire logic        new_enable,
  input  wire logic        clear_count,
  output logic             strobe,
  output logic             kind,
  output logic [1:0]       status,
  output logic [7:0]       fired_id,
  output logic [31:0]      fire_time,
  output logic [15:0]      fire_count,
  output logic [31:0]      slot_interval,
  output logic [1:0]       slot_mode,
  output logic             slot_enabled,
  output logic             last
);
  state_t state, state_next;
  logic [CNT_W-1:0] used, used_next;
  logic [IDX_W:0] step;
  logic [3:0] op;
  logic [7:0] rid;
  logic [31:0] rnow, rival;
  logic [1:0] rmode;
  logic [15:0] rlim;
  logic ren, rclr;
  logic found, removed;
  logic [3:0] fires;
  logic pend;
  slot_t pslot;

  slot_t q [NUM_SLOTS];
  slot_t head_new;
  logic head_valid, head_match, head_due;
  logic [15:0] cinc;
  logic shift;

  assign busy = (state != S_IDLE);
  assign shift = (state == S_SCAN);
  assign head_valid = (step[IDX_W-1:0] < used[IDX_W-1:0]) || (used == CNT_W'(NUM_SLOTS));
  assign head_match = head_valid && !found && (q[0].id == rid);
  assign head_due = head_valid && q[0].en && ((rnow - q[0].lt) >= q[0].ival);
  assign cinc = q[0].cnt + 16'd1;

  // head processing, the result goes to the tail
  always_comb begin
    head_new = q[0];
    unique case (op_t'(op))
      OP_TICK: if (head_due) begin
        head_new.lt = rnow;
        head_new.cnt = cinc;
        if (q[0].mode == MODE_ONCE ||
            (q[0].mode == MODE_COUNTED && cinc >= q[0].lim)) begin
          head_new.en = 1'b0;
          head_new.cnt = 16'd0;
        end
      end
      OP_START_ALL: if (head_valid) begin head_new.en = 1'b1; head_new.lt = rnow; end
      OP_STOP_ALL: if (head_valid) begin head_new.en = 1'b0; head_new.cnt = 16'd0; end
      OP_ADD: if (head_match) begin
        head_new.ival = rival; head_new.mode = rmode; head_new.lim = rlim;
        head_new.en = q[0].en | ren; head_new.lt = rnow; head_new.cnt = 16'd0;
      end
      OP_START_ONE: if (head_match) begin head_new.en = 1'b1; head_new.lt = rnow; end
      OP_START_FIRE: if (head_match) begin
        head_new.en = 1'b1; head_new.lt = rnow; head_new.cnt = cinc;
      end
      OP_STOP_ONE: if (head_match) begin
        head_new.en = 1'b0;
        if (rclr) head_new.cnt = 16'd0;
      end
      OP_CALL: if (head_match) begin
        head_new.cnt = cinc;
        if (q[0].en) head_new.lt = rnow;
      end
      default: ;
    endcase
  end

  // removal: after the match the head bypasses the tail cell, closing the gap
  slot_t tail_in;
  logic skip;
  assign skip = (op == OP_REMOVE) && removed;
  assign tail_in = head_new;

  slot_t add_slot;
  always_comb begin
    add_slot.id = rid; add_slot.ival = rival; add_slot.mode = rmode;
    add_slot.lim = rlim; add_slot.en = ren; add_slot.lt = rnow; add_slot.cnt = 16'd0;
  end
  logic append;
  assign append = (state == S_DONE) && (op == OP_ADD) && !found &&
                  (used != CNT_W'(NUM_SLOTS));

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    slot_t dsh;
    logic ld;
    if (g == NUM_SLOTS - 1) begin : g_tail
      assign dsh = tail_in;
    end else begin : g_mid
      assign dsh = (skip && g == NUM_SLOTS - 2) ? head_new : q[g+1];
    end
    assign ld = append && (used[IDX_W-1:0] == IDX_W'(g));
    mst_cell u_cell (.clk(clk), .shift(shift), .load(ld), .d_shift(dsh),
                     .d_load(add_slot), .q(q[g]));
  end

  always_comb begin
    state_next = state;
    used_next = used;
    unique case (state)
      S_IDLE: if (start) state_next = (opcode > OP_QUERY) ? S_IDLE : S_SCAN;
      S_SCAN: if (step == (IDX_W+1)'(NUM_SLOTS - 1)) state_next = S_DONE;
      S_DONE: begin
        state_next = S_IDLE;
        if (append) used_next = used + CNT_W'(1);
        if (op == OP_REMOVE && found) used_next = used - CNT_W'(1);
      end
      default: state_next = S_IDLE;
    endcase
  end

  logic tick_emit;
  assign tick_emit = (state == S_SCAN) && (op == OP_TICK) && head_due && pend &&
                     (fires != 4'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      strobe <= tick_emit || (state == S_DONE && (op != OP_TICK || pend));
    end
  end

  // tick items are held one behind so that the final one can carry last
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= opcode; rid <= event_id; rnow <= now; rival <= new_interval;
      rmode <= new_mode; rlim <= new_limit; ren <= new_enable; rclr <= clear_count;
      step <= '0; found <= 1'b0; removed <= 1'b0; fires <= '0; pend <= 1'b0;
    end else if (state == S_SCAN) begin
      step <= step + (IDX_W+1)'(1);
      if (op == OP_TICK) begin
        if (head_due && fires != 4'd8) begin
          fires <= fires + 4'd1;
          pend <= 1'b1;
          pslot <= head_new;
        end
      end else if (head_match) begin
        found <= 1'b1;
        pslot <= head_new;
        if (op == OP_REMOVE) removed <= 1'b1;
      end
    end
  end

  logic bare;
  logic [1:0] done_st;
  slot_t rs;
  always_comb begin
    rs = found ? pslot : add_slot;
    bare = 1'b1;
    done_st = ST_OK;
    if (op == OP_START_ALL || op == OP_STOP_ALL) done_st = ST_OK;
    else if (op == OP_ADD && !found && used == CNT_W'(NUM_SLOTS)) done_st = ST_FULL;
    else if (!found && op != OP_ADD) done_st = ST_NOT_FOUND;
    else if (op != OP_REMOVE) begin
      bare = 1'b0;
      done_st = (op == OP_ADD && found) ? ST_CHANGED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_emit || (state == S_DONE && op == OP_TICK)) begin
      kind <= 1'b1; status <= ST_OK; fired_id <= pslot.id; fire_time <= rnow;
      fire_count <= pslot.cnt; slot_interval <= pslot.ival; slot_mode <= pslot.mode;
      slot_enabled <= pslot.en; last <= (state == S_DONE);
    end else if (state == S_DONE) begin
      last <= 1'b1;
      kind <= !bare && (op == OP_START_FIRE || op == OP_CALL || op == OP_FORCE);
      status <= done_st;
      fired_id <= (op == OP_START_ALL || op == OP_STOP_ALL) ? 8'd0 : (bare ? rid : rs.id);
      fire_time <= bare ? 32'd0 : ((op == OP_STOP_ONE || op == OP_QUERY) ? rs.lt : rnow);
      fire_count <= bare ? 16'd0 : rs.cnt;
      slot_interval <= bare ? 32'd0 : rs.ival;
      slot_mode <= bare ? 2'd0 : rs.mode;
      slot_enabled <= bare ? 1'b0 : rs.en;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mst_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic strobe,
  input wire logic last,
  input wire logic kind,
  input wire logic [1:0] status
);
  a_idle_no_strobe: assert property (@(posedge clk) disable iff (rst)
    $past(!busy) && !busy |-> !strobe) else $error("strobe while idle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || !strobe) else $error("start not taken");
  a_kind_status: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> status == 2'd0) else $error("fired item with bad status");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !kind |-> last) else $error("status item without last");
endmodule
bind multi_slot_interval_timer mst_checker u_chk (.clk(clk), .rst(rst), .start(start),
  .busy(busy), .strobe(strobe), .last(last), .kind(kind), .status(status));
`default_nettype wire

FILE: tb/tb_multi_slot_interval_timer.sv
`timescale 1ns / 1ps
module tb_multi_slot_interval_timer;
  import mst_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  fired_id;
    logic [31:0] fire_time;
    logic [15:0] fire_count;
    logic [31:0] slot_interval;
    logic [1:0]  slot_mode;
    logic        slot_enabled;
    logic        last;
  } timer_event_t;

  typedef struct {
    logic [3:0]  op;
    logic [7:0]  id;
    logic [31:0] t;
    logic [31:0] ival;
    logic [1:0]  mode;
    logic [15:0] lim;
    logic        en;
    logic        clr;
    logic        has_fixed;
    timer_event_t fixed;
  } cmd_row_t;

  logic clk, rst, start, busy;
  logic [3:0] opcode;
  logic [7:0] event_id;
  logic [31:0] now, new_interval;
  logic [1:0] new_mode;
  logic [15:0] new_limit;
  logic new_enable, clear_count;
  logic strobe, kind, slot_enabled, last;
  logic [1:0] status, slot_mode;
  logic [7:0] fired_id;
  logic [31:0] fire_time, slot_interval;
  logic [15:0] fire_count;

  multi_slot_interval_timer DUT (.*);

  slot_t table_q[$];
  timer_event_t pending_events[$];
  bit failed = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  logic [31:0] clock_ms = 0;
  cmd_row_t rows[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic timer_event_t slot_event(logic k, logic [1:0] st, slot_t s,
                                              logic [31:0] t);
    timer_event_t e;
    e = '{kind: k, status: st, fired_id: s.id, fire_time: t, fire_count: s.cnt,
          slot_interval: s.ival, slot_mode: s.mode, slot_enabled: s.en, last: 0};
    return e;
  endfunction

  function automatic timer_event_t bare_event(logic [1:0] st, logic [7:0] id);
    timer_event_t e;
    e = '0;
    e.status = st;
    e.fired_id = id;
    e.last = 1;
    return e;
  endfunction

  task automatic predict_timer(cmd_row_t c);
    int idx;
    int n;
    slot_t s;
    timer_event_t e;
    idx = -1;
    n = 0;
    foreach (table_q[i]) if (idx < 0 && table_q[i].id == c.id) idx = i;
    if (c.op == OP_TICK) begin
      foreach (table_q[i]) begin
        s = table_q[i];
        if (s.en && (c.t - s.lt) >= s.ival) begin
          s.lt = c.t;
          s.cnt = s.cnt + 16'd1;
          if (s.mode == MODE_ONCE || (s.mode == MODE_COUNTED && s.cnt >= s.lim)) begin
            s.en = 0;
            s.cnt = 0;
          end
          table_q[i] = s;
          if (n < 8) begin
            pending_events.push_back(slot_event(1, ST_OK, s, c.t));
            n++;
          end
        end
      end
      if (n > 0) pending_events[$].last = 1;
      return;
    end
    if (c.op > OP_QUERY) return;
    if (c.op == OP_START_ALL || c.op == OP_STOP_ALL) begin
      foreach (table_q[i]) begin
        if (c.op == OP_START_ALL) begin
          table_q[i].en = 1;
          table_q[i].lt = c.t;
        end else begin
          table_q[i].en = 0;
          table_q[i].cnt = 0;
        end
      end
      pending_events.push_back(bare_event(ST_OK, 8'd0));
      return;
    end
    if (c.op == OP_ADD) begin
      if (idx >= 0) begin
        s = table_q[idx];
        s.ival = c.ival;
        s.mode = c.mode;
        s.lim = c.lim;
        s.en = s.en | c.en;
        s.lt = c.t;
        s.cnt = 0;
        table_q[idx] = s;
        e = slot_event(0, ST_CHANGED, s, c.t);
      end else if (table_q.size() >= NUM_SLOTS) begin
        e = bare_event(ST_FULL, c.id);
      end else begin
        s = '{id: c.id, ival: c.ival, mode: c.mode, lim: c.lim, en: c.en, lt: c.t, cnt: 0};
        table_q.push_back(s);
        e = slot_event(0, ST_OK, s, c.t);
      end
      e.last = 1;
      pending_events.push_back(e);
      return;
    end
    if (idx < 0) begin
      pending_events.push_back(bare_event(ST_NOT_FOUND, c.id));
      return;
    end
    s = table_q[idx];
    case (c.op)
      OP_REMOVE: begin
        table_q.delete(idx);
        e = bare_event(ST_OK, c.id);
      end
      OP_START_ONE: begin
        s.en = 1;
        s.lt = c.t;
        e = slot_event(0, ST_OK, s, c.t);
      end
      OP_START_FIRE: begin
        s.en = 1;
        s.lt = c.t;
        s.cnt = s.cnt + 16'd1;
        e = slot_event(1, ST_OK, s, c.t);
      end
      OP_STOP_ONE: begin
        s.en = 0;
        if (c.clr) s.cnt = 0;
        e = slot_event(0, ST_OK, s, s.lt);
      end
      OP_CALL: begin
        s.cnt = s.cnt + 16'd1;
        if (s.en) s.lt = c.t;
        e = slot_event(1, ST_OK, s, c.t);
      end
      OP_FORCE: e = slot_event(1, ST_OK, s, c.t);
      default: e = slot_event(0, ST_OK, s, s.lt);
    endcase
    if (c.op != OP_REMOVE) table_q[idx] = s;
    e.last = 1;
    pending_events.push_back(e);
  endtask

  always @(posedge clk) begin
    timer_event_t got, want;
    if (!rst && strobe) begin
      got = '{kind, status, fired_id, fire_time, fire_count, slot_interval, slot_mode,
              slot_enabled, last};
      if (pending_events.size() == 0) begin
        $error("unexpected result item id=%0d", fired_id);
        failed = 1;
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind) begin
          $error("kind exp %0d got %0d", want.kind, got.kind); failed = 1; end
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); failed = 1; end
        if (got.fired_id != want.fired_id) begin
          $error("fired_id exp %0d got %0d", want.fired_id, got.fired_id); failed = 1; end
        if (got.fire_time != want.fire_time) begin
          $error("fire_time exp %0h got %0h", want.fire_time, got.fire_time); failed = 1; end
        if (got.fire_count != want.fire_count) begin
          $error("fire_count exp %0d got %0d", want.fire_count, got.fire_count); failed = 1; end
        if (got.slot_interval != want.slot_interval) begin
          $error("slot_interval exp %0h got %0h", want.slot_interval, got.slot_interval);
          failed = 1;
        end
        if (got.slot_mode != want.slot_mode) begin
          $error("slot_mode exp %0d got %0d", want.slot_mode, got.slot_mode); failed = 1; end
        if (got.slot_enabled != want.slot_enabled) begin
          $error("slot_enabled exp %0d got %0d", want.slot_enabled, got.slot_enabled);
          failed = 1;
        end
        if (got.last != want.last) begin
          $error("last exp %0d got %0d", want.last, got.last); failed = 1; end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic issue_cmd(cmd_row_t c);
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start <= 1;
    opcode <= c.op;
    event_id <= c.id;
    now <= c.t;
    new_interval <= c.ival;
    new_mode <= c.mode;
    new_limit <= c.lim;
    new_enable <= c.en;
    clear_count <= c.clr;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_timer(c);
    if (c.has_fixed) begin
      if (pending_events.size() == 0) begin
        $error("fixed row has nothing to compare");
        failed = 1;
      end else if (pending_events[$] != c.fixed) begin
        $error("fixed row exp %h pred %h", c.fixed, pending_events[$]);
        failed = 1;
      end
    end
  endtask

  function automatic cmd_row_t mk(logic [3:0] op, logic [7:0] id, logic [31:0] t,
                                  logic [31:0] ival, logic [1:0] mode, logic [15:0] lim,
                                  logic en, logic clr);
    cmd_row_t c;
    c = '{op, id, t, ival, mode, lim, en, clr, 0, '0};
    return c;
  endfunction

  function automatic cmd_row_t mk_fixed(cmd_row_t c, timer_event_t e);
    c.has_fixed = 1;
    c.fixed = e;
    return c;
  endfunction

  function automatic logic [7:0] pick_id();
    if (table_q.size() > 0 && $urandom_range(99) < 80)
      return table_q[$urandom_range(table_q.size() - 1)].id;
    return 8'($urandom_range(15));
  endfunction

  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    int r;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(6);
    c = mk(OP_TICK, pick_id(), clock_ms, 32'($urandom_range(8)), 2'($urandom_range(3)),
           16'($urandom_range(4)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    if (r < 45) c.op = OP_TICK;
    else if (r < 60) c.op = OP_ADD;
    else if (r < 63) c.op = 4'(11 + $urandom_range(4));
    else c.op = 4'($urandom_range(OP_REMOVE, OP_QUERY));
    if ($urandom_range(19) == 0) begin
      c.t = $urandom;
      c.ival = $urandom;
      c.lim = 16'($urandom);
      c.id = 8'($urandom);
    end
    return c;
  endfunction

  initial begin
    cmd_row_t c;
    timer_event_t e;
    rst = 1;
    start = 0;
    opcode = OP_TICK;
    event_id = 0;
    now = 0;
    new_interval = 0;
    new_mode = 0;
    new_limit = 0;
    new_enable = 0;
    clear_count = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    e = bare_event(ST_NOT_FOUND, 8'hff);
    rows.push_back(mk_fixed(mk(OP_QUERY, 8'hff, 0, 0, 0, 0, 0, 0), e));
    rows.push_back(mk(OP_TICK, 0, 32'hffff_ffff, 0, 0, 0, 0, 0));
    e = bare_event(ST_OK, 8'd0);
    rows.push_back(mk_fixed(mk(OP_START_ALL, 0, 5, 0, 0, 0, 0, 0), e));
    rows.push_back(mk(OP_ADD, 8'h00, 32'hffff_fff0, 0, 2, 0, 1, 0));
    rows.push_back(mk(OP_ADD, 8'hff, 32'hffff_fff0, 32'h20, 0, 16'hffff, 1, 0));
    rows.push_back(mk(OP_ADD, 8'h11, 32'hffff_fff0, 2, 1, 3, 1, 1));
    rows.push_back(mk(OP_ADD, 8'h22, 0, 32'hffff_ffff, 3, 0, 0, 0));
    rows.push_back(mk(OP_TICK, 0, 32'h10, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_TICK, 0, 32'h12, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_TICK, 0, 32'h14, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_ADD, 8'h11, 32'h15, 1, 1, 0, 0, 0));
    rows.push_back(mk(OP_TICK, 0, 32'h16, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_START_ONE, 8'h22, 32'h17, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_START_FIRE, 8'h11, 32'h18, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_STOP_ONE, 8'h11, 32'h19, 0, 0, 0, 0, 1));
    rows.push_back(mk(OP_CALL, 8'h11, 32'h1a, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_CALL, 8'h00, 32'h1b, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_FORCE, 8'hff, 32'h1c, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_STOP_ONE, 8'h00, 32'h1d, 0, 0, 0, 0, 0));
    for (int k = 0; k < 5; k++)
      rows.push_back(mk(OP_ADD, 8'(8'h40 + k), 32'h20, 0, 2, 0, 1, 0));
    e = bare_event(ST_FULL, 8'h77);
    rows.push_back(mk_fixed(mk(OP_ADD, 8'h77, 32'h21, 0, 0, 0, 0, 0), e));
    rows.push_back(mk(OP_TICK, 0, 32'h22, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_REMOVE, 8'h11, 32'h23, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_STOP_ALL, 0, 32'h24, 0, 0, 0, 0, 0));
    rows.push_back(mk(4'd15, 8'h40, 32'h25, 0, 0, 0, 0, 0));
    foreach (rows[i]) issue_cmd(rows[i]);

    clock_ms = 32'hffff_ff00;
    for (int k = 0; k < 290; k++) begin
      gap_pct = (k < 100) ? 30 : (k < 200) ? 72 : 0;
      if (k == 150) begin
        start <= 0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (NUM_SLOTS + 4) @(posedge clk);
      end
      c = random_cmd();
      if (c.op == OP_REMOVE && table_q.size() < 3) c.op = OP_ADD;
      issue_cmd(c);
    end

    start <= 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4 * NUM_SLOTS) @(posedge clk);
    if (!failed && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
